>>> hdl/xalu_pkg.sv
package xalu_pkg;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_ADC   = 4'd1,
    MODE_SUB   = 4'd2,
    MODE_SBB   = 4'd3,
    MODE_LOGIC = 4'd4,
    MODE_INC   = 4'd5,
    MODE_DEC   = 4'd6,
    MODE_SHL   = 4'd7,
    MODE_SHR   = 4'd8,
    MODE_SAR   = 4'd9,
    MODE_IMUL  = 4'd10,
    MODE_DIV   = 4'd11,
    MODE_IDIV  = 4'd12,
    MODE_COND  = 4'd13,
    MODE_CLEAR = 4'd14,
    MODE_NONE  = 4'd15
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_DIV_ZERO = 2'd1,
    FAULT_DIV_OVF  = 2'd2,
    FAULT_QUOT_OVF = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FIX  = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_high;
    logic [1:0]  width_code;
    logic [3:0]  cond_select;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [31:0] remainder_value;
    logic [1:0]  fault_code;
    logic        condition_true;
    logic [4:0]  flags_out;
  } out_item_t;

  // Flag bit positions within flags_out.
  localparam int FlagC = 0;
  localparam int FlagZ = 1;
  localparam int FlagS = 2;
  localparam int FlagO = 3;
  localparam int FlagP = 4;

  localparam int DivSteps = 64;

endpackage

>>> hdl/xalu_if.sv
interface xalu_in_if;
  logic                valid;
  logic                ready;
  xalu_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface xalu_out_if;
  logic                valid;
  logic                ready;
  xalu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/xalu_divider.sv
// Restoring 64/32 unsigned divider, one quotient bit per cycle.
module xalu_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [32:0] remainder
);

  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  count;
  logic        busy;
  logic [33:0] trial;
  logic [32:0] shifted;

  // Shift one dividend bit into the partial remainder and try a subtract.
  always_comb begin
    shifted = {rem[31:0], quo[63]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        if (trial[33]) begin
          rem <= shifted;
          quo <= {quo[62:0], 1'b0};
        end else begin
          rem <= trial[32:0];
          quo <= {quo[62:0], 1'b1};
        end
        count <= count + 7'd1;
        if (count == 7'(xalu_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> hdl/x86_integer_alu_with_flags.sv
// An op other than a full divide is worked out in the fix-up state and its
// result offered from the output state; div and idiv first pass through the
// divide state (64 quotient bits, one per cycle), save a zero divisor or the
// most negative dividend over -1, which go straight to the output state. One
// item at a time: not ready again until the result transfer completes.
// Reset: synchronous, active high; clears all five flags and the sequencer.
module x86_integer_alu_with_flags (
  input logic clk,
  input logic rst,
  xalu_in_if.sink    in_ch,
  xalu_out_if.source out_ch
);

  xalu_pkg::state_t   state, state_next;
  xalu_pkg::in_item_t item;
  logic [4:0]         flags, flags_next;
  xalu_pkg::out_item_t res, res_next;
  logic               div_start, div_done;
  logic [63:0]        div_quo;
  logic [32:0]        div_rem;
  logic [63:0]        dividend_mag;
  logic [31:0]        divisor_mag;
  logic               num_neg, den_neg;

  // Width-dependent helpers.
  logic [5:0]  bits;
  logic [31:0] mask, sbit, a_m, b_m;
  logic [4:0]  cnt;
  logic [32:0] sum;
  logic [31:0] v;
  logic        c, o, cin;
  logic [63:0] ext_a, ext_b, prod, prod_chk;
  logic [63:0] sar_ext;
  logic [31:0] sh_tmp;
  logic        msb;
  logic        cond;
  logic        szp;

  always_comb begin
    case (item.width_code)
      2'd0:    bits = 6'd8;
      2'd1:    bits = 6'd16;
      default: bits = 6'd32;
    endcase
    mask = (bits == 6'd32) ? 32'hffffffff : ((32'd1 << bits) - 32'd1);
    sbit = 32'd1 << (bits - 6'd1);
    a_m  = item.operand_a & mask;
    b_m  = item.operand_b & mask;
    cnt  = item.operand_b[4:0];
    msb  = (a_m & sbit) != 0;
  end

  // Division operands: signed magnitudes for idiv, unsigned values as given for div.
  always_comb begin
    num_neg      = item.operand_high[31];
    den_neg      = item.operand_b[31];
    dividend_mag = num_neg ? (64'd0 - {item.operand_high, item.operand_a})
                           : {item.operand_high, item.operand_a};
    divisor_mag  = den_neg ? (32'd0 - item.operand_b) : item.operand_b;
    if (item.mode == xalu_pkg::MODE_DIV) begin
      dividend_mag = {item.operand_high, item.operand_a};
      divisor_mag  = item.operand_b;
    end
  end

  xalu_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend_mag),
    .divisor   (divisor_mag),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Condition evaluation on the stored flags.
  always_comb begin
    case (item.cond_select)
      4'd0:    cond = flags[xalu_pkg::FlagZ];
      4'd1:    cond = !flags[xalu_pkg::FlagZ];
      4'd2:    cond = flags[xalu_pkg::FlagS] != flags[xalu_pkg::FlagO];
      4'd3:    cond = flags[xalu_pkg::FlagS] == flags[xalu_pkg::FlagO];
      4'd4:    cond = flags[xalu_pkg::FlagZ] ||
                      (flags[xalu_pkg::FlagS] != flags[xalu_pkg::FlagO]);
      4'd5:    cond = !flags[xalu_pkg::FlagZ] &&
                      (flags[xalu_pkg::FlagS] == flags[xalu_pkg::FlagO]);
      4'd6:    cond = flags[xalu_pkg::FlagC];
      4'd7:    cond = !flags[xalu_pkg::FlagC];
      4'd8:    cond = flags[xalu_pkg::FlagC] || flags[xalu_pkg::FlagZ];
      4'd9:    cond = !flags[xalu_pkg::FlagC] && !flags[xalu_pkg::FlagZ];
      4'd10:   cond = flags[xalu_pkg::FlagS];
      4'd11:   cond = !flags[xalu_pkg::FlagS];
      4'd12:   cond = flags[xalu_pkg::FlagO];
      4'd13:   cond = !flags[xalu_pkg::FlagO];
      4'd14:   cond = flags[xalu_pkg::FlagP];
      default: cond = !flags[xalu_pkg::FlagP];
    endcase
  end

  // Combinational datapath for everything except divide.
  always_comb begin
    flags_next = flags;
    v          = '0;
    c          = flags[xalu_pkg::FlagC];
    o          = flags[xalu_pkg::FlagO];
    szp        = 1'b0;
    cin        = flags[xalu_pkg::FlagC];
    sum        = '0;
    sh_tmp     = '0;
    sar_ext    = '0;
    ext_a      = '0;
    ext_b      = '0;
    prod       = '0;
    prod_chk   = '0;
    case (xalu_pkg::mode_t'(item.mode))
      xalu_pkg::MODE_ADD, xalu_pkg::MODE_ADC, xalu_pkg::MODE_INC: begin
        if (item.mode == xalu_pkg::MODE_INC) begin
          sum = {1'b0, a_m} + 33'd1;
          sh_tmp = 32'd1;
        end else begin
          sum = {1'b0, a_m} + {1'b0, b_m} +
                {32'd0, (item.mode == xalu_pkg::MODE_ADC) & cin};
          sh_tmp = b_m;
        end
        v = sum[31:0] & mask;
        if (item.mode != xalu_pkg::MODE_INC) c = sum > {1'b0, mask};
        o = ((~(a_m ^ sh_tmp) & (a_m ^ v)) & sbit) != 0;
        szp = 1'b1;
      end
      xalu_pkg::MODE_SUB, xalu_pkg::MODE_SBB, xalu_pkg::MODE_DEC: begin
        if (item.mode == xalu_pkg::MODE_DEC) begin
          sh_tmp = 32'd1;
          sum = {1'b0, a_m} - 33'd1;
        end else begin
          sh_tmp = b_m;
          sum = {1'b0, a_m} - {1'b0, b_m} -
                {32'd0, (item.mode == xalu_pkg::MODE_SBB) & cin};
        end
        v = sum[31:0] & mask;
        if (item.mode != xalu_pkg::MODE_DEC) c = sum[32];
        o = (((a_m ^ sh_tmp) & (a_m ^ v)) & sbit) != 0;
        szp = 1'b1;
      end
      xalu_pkg::MODE_LOGIC: begin
        v = a_m;
        c = 1'b0;
        o = 1'b0;
        szp = 1'b1;
      end
      xalu_pkg::MODE_SHL: begin
        v = a_m;
        if (cnt != 5'd0) begin
          c = ({1'b0, cnt} <= bits) && a_m[5'(bits - {1'b0, cnt})];
          v = (a_m << cnt) & mask;
          if (cnt == 5'd1) o = ((v & sbit) != 0) != c;
          szp = 1'b1;
        end
      end
      xalu_pkg::MODE_SHR: begin
        v = a_m;
        if (cnt != 5'd0) begin
          c = ({1'b0, cnt} <= bits) && a_m[cnt - 5'd1];
          v = ({1'b0, cnt} >= bits) ? 32'd0 : (a_m >> cnt);
          if (cnt == 5'd1) o = msb;
          szp = 1'b1;
        end
      end
      xalu_pkg::MODE_SAR: begin
        v = a_m;
        if (cnt != 5'd0) begin
          c = ({1'b0, cnt} >= bits) ? msb : a_m[cnt - 5'd1];
          sar_ext = {32'd0, a_m} | (msb ? ~{32'd0, mask} : 64'd0);
          sh_tmp = 32'(sar_ext >> cnt);
          v = sh_tmp & mask;
          if (cnt == 5'd1) o = 1'b0;
          szp = 1'b1;
        end
      end
      xalu_pkg::MODE_IMUL: begin
        ext_a = ((a_m & sbit) != 0) ? ({32'd0, a_m} | ~{32'd0, mask}) : {32'd0, a_m};
        ext_b = ((b_m & sbit) != 0) ? ({32'd0, b_m} | ~{32'd0, mask}) : {32'd0, b_m};
        prod  = $signed(ext_a[32:0]) * $signed(ext_b[32:0]);
        v     = prod[31:0] & mask;
        prod_chk = ((v & sbit) != 0) ? ({32'd0, v} | ~{32'd0, mask}) : {32'd0, v};
        c = prod != prod_chk;
        o = c;
      end
      xalu_pkg::MODE_CLEAR: begin
        c = 1'b0;
        o = 1'b0;
      end
      default: ;
    endcase
    flags_next[xalu_pkg::FlagC] = c;
    flags_next[xalu_pkg::FlagO] = o;
    if (szp) begin
      flags_next[xalu_pkg::FlagZ] = v == 32'd0;
      flags_next[xalu_pkg::FlagS] = (v & sbit) != 0;
      flags_next[xalu_pkg::FlagP] = ~^v[7:0];
    end
    if (item.mode == xalu_pkg::MODE_CLEAR) flags_next = '0;
  end

  logic [31:0] q_lo, r_lo;
  logic        q_bad;

  // Divide fix-up: sign of quotient and remainder, and range of the quotient.
  always_comb begin
    q_lo  = div_quo[31:0];
    r_lo  = div_rem[31:0];
    q_bad = div_quo[63:32] != 32'd0;
    if (item.mode == xalu_pkg::MODE_IDIV) begin
      if (num_neg != den_neg) begin
        q_lo  = 32'd0 - div_quo[31:0];
        q_bad = q_bad || (div_quo[31:0] > 32'h80000000);
      end else begin
        q_bad = q_bad || div_quo[31];
      end
      if (num_neg) r_lo = 32'd0 - div_rem[31:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    res_next   = res;
    div_start  = 1'b0;
    in_ch.ready = state == xalu_pkg::ST_IDLE;
    case (state)
      xalu_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = xalu_pkg::ST_FIX;
      end
      xalu_pkg::ST_FIX: begin
        res_next = '0;
        res_next.flags_out = flags_next;
        if (item.mode == xalu_pkg::MODE_DIV || item.mode == xalu_pkg::MODE_IDIV) begin
          res_next.flags_out = flags;
          if (item.operand_b == 32'd0) begin
            res_next.fault_code = xalu_pkg::FAULT_DIV_ZERO;
            state_next = xalu_pkg::ST_OUT;
          end else if (item.mode == xalu_pkg::MODE_IDIV &&
                       {item.operand_high, item.operand_a} == 64'h8000000000000000 &&
                       item.operand_b == 32'hffffffff) begin
            res_next.fault_code = xalu_pkg::FAULT_DIV_OVF;
            state_next = xalu_pkg::ST_OUT;
          end else begin
            div_start  = 1'b1;
            state_next = xalu_pkg::ST_DIV;
          end
        end else begin
          res_next.result_value = v;
          res_next.condition_true = (item.mode == xalu_pkg::MODE_COND) & cond;
          state_next = xalu_pkg::ST_OUT;
        end
      end
      xalu_pkg::ST_DIV: begin
        if (div_done) begin
          if (q_bad) begin
            res_next.fault_code = xalu_pkg::FAULT_QUOT_OVF;
          end else begin
            res_next.result_value    = q_lo;
            res_next.remainder_value = r_lo;
          end
          state_next = xalu_pkg::ST_OUT;
        end
      end
      xalu_pkg::ST_OUT: begin
        if (out_ch.ready) state_next = xalu_pkg::ST_IDLE;
      end
      default: state_next = xalu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xalu_pkg::ST_IDLE;
      flags <= '0;
    end else begin
      state <= state_next;
      if (state == xalu_pkg::ST_FIX) flags <= res_next.flags_out;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) item <= in_ch.data;
    res <= res_next;
  end

  assign out_ch.valid = state == xalu_pkg::ST_OUT;
  assign out_ch.data  = res;

  // A result is only offered from the output state.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a result waits");

  // Flags change only on leaving the fix-up state.
  assert property (@(posedge clk) disable iff (rst)
    (state != xalu_pkg::ST_FIX) |=> $stable(flags))
    else $error("flags changed outside finish");

  // Divider completion comes only while dividing.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == xalu_pkg::ST_DIV)
    else $error("divider done outside divide");

endmodule
